// ----- hdl/bfhp_pkg.sv -----
// Shared types and constants for the bit file header parser.
// Holds the preamble table, tag bytes, result kinds, status codes and the result struct.
// No dependencies.
package bfhp_pkg;

	localparam int unsigned PreambleLen = 13;

	localparam logic [7:0] TagA = 8'h61;
	localparam logic [7:0] TagD = 8'h64;
	localparam logic [7:0] TagE = 8'h65;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_META    = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_BAD_PRE     = 4'd1,
		ST_BAD_TAG     = 4'd2,
		ST_TRUNCATED   = 4'd3,
		ST_SEC_OVERRUN = 4'd4,
		ST_PAY_OVERRUN = 4'd5,
		ST_TRAILING    = 4'd6,
		ST_DONE        = 4'd7,
		ST_NO_PAYLOAD  = 4'd8
	} status_t;

	typedef struct packed {
		logic        emit;
		logic [7:0]  data;
		kind_t       kind;
		logic [1:0]  tag;
		logic        run_last;
		logic [31:0] plen;
		status_t     status;
	} result_t;

	function automatic logic [7:0] preamble_byte(input logic [3:0] pos);
		logic [7:0] b;
		unique case (pos)
			4'd0:    b = 8'h00;
			4'd1:    b = 8'h09;
			4'd2:    b = 8'h0f;
			4'd3:    b = 8'hf0;
			4'd4:    b = 8'h0f;
			4'd5:    b = 8'hf0;
			4'd6:    b = 8'h0f;
			4'd7:    b = 8'hf0;
			4'd8:    b = 8'h0f;
			4'd9:    b = 8'hf0;
			4'd10:   b = 8'h00;
			4'd11:   b = 8'h00;
			4'd12:   b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- hdl/bfhp_core.sv -----
// Parser state and the single-byte step logic of the bit file header parser.
// Depends on bfhp_pkg.
module bfhp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           byte_in,
	input  logic                 last_in,
	output bfhp_pkg::result_t    res
);

	typedef enum logic [3:0] {
		PH_PRE    = 4'd0,
		PH_TAG    = 4'd1,
		PH_SLEN   = 4'd2,
		PH_SDATA  = 4'd3,
		PH_PLEN   = 4'd4,
		PH_PDATA  = 4'd5,
		PH_DONE   = 4'd6,
		PH_BADPRE = 4'd7,
		PH_BADTAG = 4'd8
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  pre_pos_q, pre_pos_d;
	logic [31:0] len_acc_q, len_acc_d;
	logic [31:0] left_q, left_d;
	logic [1:0]  section_q, section_d;
	logic        trailing_q, trailing_d;
	logic        failed_q, failed_d;

	always_comb begin
		logic [31:0] left_dec;
		phase_d    = phase_q;
		pre_pos_d  = pre_pos_q;
		len_acc_d  = len_acc_q;
		left_d     = left_q;
		section_d  = section_q;
		trailing_d = trailing_q;
		failed_d   = failed_q;
		res.emit     = 1'b0;
		res.data     = 8'd0;
		res.kind     = bfhp_pkg::KIND_STATUS;
		res.tag      = 2'd0;
		res.run_last = 1'b0;
		res.plen     = 32'd0;
		res.status   = bfhp_pkg::ST_OK;
		left_dec = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;

		if (!failed_q) begin
			unique case (phase_q)
				PH_PRE: begin
					if (pre_pos_q >= 4'(bfhp_pkg::PreambleLen) ||
					    byte_in != bfhp_pkg::preamble_byte(pre_pos_q)) begin
						failed_d   = 1'b1;
						phase_d    = PH_BADPRE;
						res.emit   = 1'b1;
						res.status = bfhp_pkg::ST_BAD_PRE;
					end else begin
						pre_pos_d = pre_pos_q + 4'd1;
						if (pre_pos_d == 4'(bfhp_pkg::PreambleLen)) begin
							phase_d = PH_TAG;
						end
					end
				end
				PH_TAG: begin
					if (byte_in == bfhp_pkg::TagE) begin
						phase_d   = PH_PLEN;
						left_d    = 32'd4;
						len_acc_d = 32'd0;
					end else if (byte_in >= bfhp_pkg::TagA && byte_in <= bfhp_pkg::TagD) begin
						section_d = 2'(byte_in - bfhp_pkg::TagA);
						phase_d   = PH_SLEN;
						left_d    = 32'd2;
						len_acc_d = 32'd0;
					end else begin
						failed_d   = 1'b1;
						phase_d    = PH_BADTAG;
						res.emit   = 1'b1;
						res.status = bfhp_pkg::ST_BAD_TAG;
					end
				end
				PH_SLEN, PH_PLEN: begin
					len_acc_d = {len_acc_q[23:0], byte_in};
					left_d    = left_dec;
					if (left_dec == 32'd0) begin
						if (len_acc_d == 32'd0) begin
							phase_d = (phase_q == PH_SLEN) ? PH_TAG : PH_DONE;
						end else begin
							left_d  = len_acc_d;
							phase_d = (phase_q == PH_SLEN) ? PH_SDATA : PH_PDATA;
						end
					end
				end
				PH_SDATA, PH_PDATA: begin
					res.emit     = 1'b1;
					res.data     = byte_in;
					res.kind     = (phase_q == PH_SDATA) ? bfhp_pkg::KIND_META
					                                     : bfhp_pkg::KIND_PAYLOAD;
					res.tag      = (phase_q == PH_SDATA) ? section_q : 2'd0;
					res.run_last = (left_q <= 32'd1);
					left_d       = left_dec;
					if (left_dec == 32'd0) begin
						phase_d = (phase_q == PH_SDATA) ? PH_TAG : PH_DONE;
					end
				end
				PH_DONE: begin
					if (!trailing_q) begin
						trailing_d = 1'b1;
						res.emit   = 1'b1;
						res.status = bfhp_pkg::ST_TRAILING;
					end
				end
				default: begin
				end
			endcase
		end

		if (!failed_d && (phase_d == PH_PDATA || phase_d == PH_DONE)) begin
			res.plen = len_acc_d;
		end

		if (last_in) begin
			res.emit = 1'b1;
			if (failed_d) begin
				res.status = (phase_d == PH_BADPRE) ? bfhp_pkg::ST_BAD_PRE
				                                    : bfhp_pkg::ST_BAD_TAG;
			end else begin
				unique case (phase_d)
					PH_TAG:            res.status = bfhp_pkg::ST_NO_PAYLOAD;
					PH_SLEN, PH_PLEN:  res.status = bfhp_pkg::ST_TRUNCATED;
					PH_SDATA:          res.status = bfhp_pkg::ST_SEC_OVERRUN;
					PH_PDATA:          res.status = bfhp_pkg::ST_PAY_OVERRUN;
					PH_DONE:           res.status = trailing_d ? bfhp_pkg::ST_TRAILING
					                                           : bfhp_pkg::ST_DONE;
					default:           res.status = bfhp_pkg::ST_BAD_PRE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PRE;
			pre_pos_q  <= 4'd0;
			len_acc_q  <= 32'd0;
			left_q     <= 32'd0;
			section_q  <= 2'd0;
			trailing_q <= 1'b0;
			failed_q   <= 1'b0;
		end else if (fire) begin
			if (last_in) begin
				phase_q    <= PH_PRE;
				pre_pos_q  <= 4'd0;
				len_acc_q  <= 32'd0;
				left_q     <= 32'd0;
				section_q  <= 2'd0;
				trailing_q <= 1'b0;
				failed_q   <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				pre_pos_q  <= pre_pos_d;
				len_acc_q  <= len_acc_d;
				left_q     <= left_d;
				section_q  <= section_d;
				trailing_q <= trailing_d;
				failed_q   <= failed_d;
			end
		end
	end

endmodule

// ----- hdl/fpga_bitfile_header_parser_top.sv -----
// Top level of the bit file header parser: input register, parser core, result register.
// Depends on bfhp_pkg and bfhp_core.
//
// The block takes a configuration bit file one byte per beat on the input channel
// (in_valid, in_stall, in_byte, file_last) and gives zero or one result beat per
// input beat on the output channel (out_valid, out_stall and the result fields).
// Metadata bytes of sections a to d come out with out_kind 1 and their section
// tag, payload bytes of section e with out_kind 0, and status-only beats with
// out_kind 2. The beat for the byte marked file_last always carries the final
// status, and the parser then rearms for the next file.
// A byte accepted into the input register is parsed by the core from there, and
// its result beat is captured in the result register. One byte is taken every
// cycle while the receiver does not stall; the parser state updates once per byte.
// Reset clears the parser state and empties both registers, so the next byte is
// taken as the first byte of a new file. When the receiver stalls, the result
// register holds its beat, the byte in the input register waits, and in_stall
// rises in the same cycle while the input register holds a byte; no byte or result is dropped.
module fpga_bitfile_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        file_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  out_kind,
	output logic [1:0]  section_tag,
	output logic        run_last,
	output logic [31:0] payload_length,
	output logic [3:0]  status
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               out_valid_q;
	bfhp_pkg::result_t  res;
	bfhp_pkg::result_t  res_q;
	logic               out_free;
	logic               step_fire;
	logic               in_fire;

	assign out_free  = !out_valid_q || !out_stall;
	assign step_fire = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_fire   = in_valid && !in_stall;

	bfhp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (step_fire),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_byte;
			last_s1 <= file_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step_fire && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = res_q.data;
	assign out_kind       = res_q.kind;
	assign section_tag    = res_q.tag;
	assign run_last       = res_q.run_last;
	assign payload_length = res_q.plen;
	assign status         = res_q.status;

endmodule

// ----- verif/fpga_bitfile_header_parser_top_test.sv -----
// Self-checking testbench for fpga_bitfile_header_parser_top: streams bit files byte by byte
// and compares every result beat with a predictor of the parser. Depends on bfhp_pkg and the
// RTL of the parser.
module fpga_bitfile_header_parser_top_test;

	localparam int LIMIT = 200000;
	localparam int RANDOM_BYTES = 1700;
	localparam logic [103:0] PREAMBLE_BYTES = 104'h00_09_0f_f0_0f_f0_0f_f0_0f_f0_00_00_01;

	typedef enum logic [3:0] {
		PH_PRE, PH_TAG, PH_SLEN, PH_SDATA, PH_PLEN, PH_PDATA, PH_DONE, PH_BADPRE, PH_BADTAG
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} file_beat_t;

	typedef struct packed {
		logic [7:0]        data;
		bfhp_pkg::kind_t   kind;
		logic [1:0]        tag;
		logic              run_last;
		logic [31:0]       plen;
		bfhp_pkg::status_t status;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        file_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  out_kind;
	logic [1:0]  section_tag;
	logic        run_last;
	logic [31:0] payload_length;
	logic [3:0]  status;

	file_beat_t    pending_bytes[$];
	logic [7:0]    file_buf[$];
	parse_result_t expected_results[$];
	file_beat_t    next_beat;
	parse_result_t got_result;
	int            cycle = 0;
	int            errors = 0;

	parse_phase_t  ph;
	int unsigned   pre_pos;
	logic [31:0]   len_acc;
	logic [31:0]   remaining;
	logic [1:0]    cur_sec;
	logic          trail_seen;
	logic          held_err;

	fpga_bitfile_header_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.file_last(file_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_kind(out_kind),
		.section_tag(section_tag),
		.run_last(run_last),
		.payload_length(payload_length),
		.status(status)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
	end

	function automatic bit gaps_on();
		return !(cycle >= 1200 && cycle < 2400);
	endfunction

	task automatic rearm_parser();
		ph = PH_PRE;
		pre_pos = 0;
		len_acc = '0;
		remaining = '0;
		cur_sec = '0;
		trail_seen = 1'b0;
		held_err = 1'b0;
	endtask

	function automatic bfhp_pkg::status_t final_status();
		if (held_err) begin
			if (ph == PH_BADPRE)
				return bfhp_pkg::ST_BAD_PRE;
			return bfhp_pkg::ST_BAD_TAG;
		end
		unique case (ph)
			PH_PRE:   return bfhp_pkg::ST_BAD_PRE;
			PH_TAG:   return bfhp_pkg::ST_NO_PAYLOAD;
			PH_SLEN:  return bfhp_pkg::ST_TRUNCATED;
			PH_PLEN:  return bfhp_pkg::ST_TRUNCATED;
			PH_SDATA: return bfhp_pkg::ST_SEC_OVERRUN;
			PH_PDATA: return bfhp_pkg::ST_PAY_OVERRUN;
			PH_DONE: begin
				if (trail_seen)
					return bfhp_pkg::ST_TRAILING;
				return bfhp_pkg::ST_DONE;
			end
			default:  return bfhp_pkg::ST_BAD_PRE;
		endcase
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic last);
		parse_result_t res;
		logic          emit;
		logic [7:0]    off;
		res = '{data: 8'h00, kind: bfhp_pkg::KIND_STATUS, tag: 2'd0, run_last: 1'b0,
			plen: 32'd0, status: bfhp_pkg::ST_OK};
		emit = 1'b0;
		if (!held_err) begin
			unique case (ph)
				PH_PRE: begin
					if (pre_pos >= bfhp_pkg::PreambleLen ||
					    b != PREAMBLE_BYTES[103 - 8 * pre_pos -: 8]) begin
						held_err = 1'b1;
						ph = PH_BADPRE;
						emit = 1'b1;
						res.status = bfhp_pkg::ST_BAD_PRE;
					end else begin
						pre_pos++;
						if (pre_pos == bfhp_pkg::PreambleLen)
							ph = PH_TAG;
					end
				end
				PH_TAG: begin
					if (b == bfhp_pkg::TagE) begin
						ph = PH_PLEN;
						remaining = 32'd4;
						len_acc = '0;
					end else if (b >= bfhp_pkg::TagA && b <= bfhp_pkg::TagD) begin
						off = b - bfhp_pkg::TagA;
						cur_sec = off[1:0];
						ph = PH_SLEN;
						remaining = 32'd2;
						len_acc = '0;
					end else begin
						held_err = 1'b1;
						ph = PH_BADTAG;
						emit = 1'b1;
						res.status = bfhp_pkg::ST_BAD_TAG;
					end
				end
				PH_SLEN, PH_PLEN: begin
					len_acc = {len_acc[23:0], b};
					if (remaining != 0)
						remaining--;
					if (remaining == 0) begin
						if (len_acc == 0) begin
							ph = (ph == PH_SLEN) ? PH_TAG : PH_DONE;
						end else begin
							remaining = len_acc;
							ph = (ph == PH_SLEN) ? PH_SDATA : PH_PDATA;
						end
					end
				end
				PH_SDATA, PH_PDATA: begin
					emit = 1'b1;
					res.data = b;
					if (ph == PH_SDATA) begin
						res.kind = bfhp_pkg::KIND_META;
						res.tag = cur_sec;
					end else begin
						res.kind = bfhp_pkg::KIND_PAYLOAD;
					end
					res.run_last = (remaining <= 1);
					if (remaining != 0)
						remaining--;
					if (remaining == 0)
						ph = (ph == PH_SDATA) ? PH_TAG : PH_DONE;
				end
				PH_DONE: begin
					if (!trail_seen) begin
						trail_seen = 1'b1;
						emit = 1'b1;
						res.status = bfhp_pkg::ST_TRAILING;
					end
				end
				default: begin
				end
			endcase
		end
		if (!held_err && (ph == PH_PDATA || ph == PH_DONE))
			res.plen = len_acc;
		if (last) begin
			emit = 1'b1;
			res.status = final_status();
		end
		if (emit)
			expected_results.push_back(res);
		if (last)
			rearm_parser();
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			file_last <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				parse_byte(in_byte, file_last);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && !(gaps_on() && $urandom_range(99) < 22)) begin
					next_beat = pending_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= next_beat.data;
					file_last <= next_beat.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with none expected: byte %0h status %0d", out_byte, status);
					errors++;
				end else begin
					got_result = expected_results.pop_front();
					check_field("out_byte", got_result.data, out_byte);
					check_field("out_kind", got_result.kind, out_kind);
					check_field("section_tag", got_result.tag, section_tag);
					check_field("run_last", got_result.run_last, run_last);
					check_field("payload_length", got_result.plen, payload_length);
					check_field("status", got_result.status, status);
				end
			end
			out_stall <= gaps_on() && ($urandom_range(99) < 22);
		end
	end

	task automatic flush_file(input int keep);
		for (int i = 0; i < keep; i++)
			pending_bytes.push_back('{data: file_buf[i], last: (i == keep - 1)});
		file_buf.delete();
	endtask

	task automatic add_preamble();
		for (int i = 0; i < bfhp_pkg::PreambleLen; i++)
			file_buf.push_back(PREAMBLE_BYTES[103 - 8 * i -: 8]);
	endtask

	task automatic add_random_bytes(input int n);
		for (int i = 0; i < n; i++)
			file_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_random_file();
		logic [31:0] len;
		logic [7:0]  b;
		bit          stop;
		int          keep;
		int          nsec;
		int          pos;
		stop = 1'b0;
		if ($urandom_range(99) < 6) begin
			add_random_bytes($urandom_range(1, 6));
		end else begin
			add_preamble();
			if ($urandom_range(99) < 6) begin
				pos = $urandom_range(0, 12);
				file_buf[pos] = file_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
			nsec = $urandom_range(0, 4);
			for (int s = 0; s < nsec && !stop; s++) begin
				if ($urandom_range(99) < 4) begin
					do b = 8'($urandom_range(0, 255));
					while (b >= bfhp_pkg::TagA && b <= bfhp_pkg::TagE);
					file_buf.push_back(b);
					stop = 1'b1;
				end else begin
					file_buf.push_back(8'(bfhp_pkg::TagA + $urandom_range(0, 3)));
					len = ($urandom_range(99) < 5) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
					file_buf.push_back(len[15:8]);
					file_buf.push_back(len[7:0]);
					if (len > 40) begin
						add_random_bytes($urandom_range(0, 20));
						stop = 1'b1;
					end else begin
						add_random_bytes(len);
					end
				end
			end
			if (!stop && $urandom_range(99) < 88) begin
				file_buf.push_back(bfhp_pkg::TagE);
				len = ($urandom_range(99) < 5) ? $urandom() : $urandom_range(0, 12);
				file_buf.push_back(len[31:24]);
				file_buf.push_back(len[23:16]);
				file_buf.push_back(len[15:8]);
				file_buf.push_back(len[7:0]);
				if (len > 40) begin
					add_random_bytes($urandom_range(0, 20));
				end else begin
					add_random_bytes(len);
					if ($urandom_range(99) < 25)
						add_random_bytes($urandom_range(1, 3));
				end
			end
		end
		keep = file_buf.size();
		if (keep > 1 && $urandom_range(99) < 15)
			keep = $urandom_range(1, keep);
		flush_file(keep);
	endtask

	initial begin
		rearm_parser();

		// A wrong first byte is flagged at once and again on the final byte.
		file_buf.push_back(8'hff);
		file_buf.push_back(8'h00);
		flush_file(2);
		// The file ends inside the preamble.
		file_buf.push_back(8'h00);
		flush_file(1);
		// An empty section, a one-byte payload and two trailing bytes.
		add_preamble();
		file_buf.push_back(bfhp_pkg::TagD);
		file_buf.push_back(8'h00);
		file_buf.push_back(8'h00);
		file_buf.push_back(bfhp_pkg::TagE);
		file_buf.push_back(8'h00);
		file_buf.push_back(8'h00);
		file_buf.push_back(8'h00);
		file_buf.push_back(8'h01);
		file_buf.push_back(8'hff);
		file_buf.push_back(8'h00);
		file_buf.push_back(8'h5a);
		flush_file(file_buf.size());

		while (pending_bytes.size() < RANDOM_BYTES + 27)
			build_random_file();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) &&
				cycle < LIMIT)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (cycle < LIMIT && errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/bfhp_pkg.sv
hdl/bfhp_core.sv
hdl/fpga_bitfile_header_parser_top.sv
verif/fpga_bitfile_header_parser_top_test.sv
